// ===== src/sccc_pkg.sv =====
// Shared types, constants and helper functions for the scaled calendar clock.
// Used by sccc_minute_unit, sccc_calendar and scaled_calendar_clock; no dependencies.
package sccc_pkg;

	// Time scale in Q7.8: 1x after reset, 100x at most.
	localparam logic [14:0] SCALE_RESET = 15'd256;
	localparam logic [14:0] SCALE_MAX   = 15'd25600;

	// Minute store width and one hour in units of 2^-18 minute.
	localparam int          MIN_W    = 31;
	localparam logic [30:0] HOUR_FIX = 31'd15728640;

	localparam logic [4:0] HOURS_PER_DAY   = 5'd24;
	localparam logic [3:0] MONTHS_PER_YEAR = 4'd12;

	// Calendar after reset: January 1, 2024, 06:00.
	localparam int         YEAR_RESET      = 2024;
	localparam logic [6:0] YMOD100_RESET   = 7'd24;
	localparam logic [1:0] CENTMOD4_RESET  = 2'd0;
	localparam logic [4:0] HOUR_RESET      = 5'd6;

	typedef enum logic [2:0] {
		PH_NIGHT     = 3'd0,
		PH_DAWN      = 3'd1,
		PH_MORNING   = 3'd2,
		PH_NOON      = 3'd3,
		PH_AFTERNOON = 3'd4,
		PH_DUSK      = 3'd5,
		PH_MIDNIGHT  = 3'd6
	} day_phase_t;

	// Control strobes from the sequencer to the minute datapath.
	typedef struct packed {
		logic load;  // multiply ticks by the scale
		logic x60;   // times 60 to get the minute increment
		logic add;   // add the increment to the minute store
		logic sub;   // take one hour off the minute store
	} minute_ctrl_t;

	function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
		logic [4:0] len;
		unique case (month)
			4'd2:                    len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			default:                 len = 5'd31;
		endcase
		return len;
	endfunction

	function automatic day_phase_t phase_of(input logic [4:0] hour);
		day_phase_t ph;
		if (hour < 5'd6)       ph = PH_NIGHT;
		else if (hour < 5'd8)  ph = PH_DAWN;
		else if (hour < 5'd11) ph = PH_MORNING;
		else if (hour < 5'd13) ph = PH_NOON;
		else if (hour < 5'd16) ph = PH_AFTERNOON;
		else if (hour < 5'd18) ph = PH_DUSK;
		else if (hour < 5'd22) ph = PH_NIGHT;
		else                   ph = PH_MIDNIGHT;
		return ph;
	endfunction

endpackage

// ===== src/sccc_minute_unit.sv =====
// Minute datapath: scale multiply, times-60 step and the shared hour subtract/compare.
// Depends on sccc_pkg.
module sccc_minute_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  sccc_pkg::minute_ctrl_t ctrl,
	input  logic [9:0]          delta_ticks,
	input  logic [14:0]         scale,
	output logic [23:0]         minute,
	output logic                hour_over
);
	import sccc_pkg::*;

	logic [24:0]      prod_q;
	logic [MIN_W-1:0] inc_q;
	logic [MIN_W-1:0] min_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			prod_q <= 25'(delta_ticks) * 25'(scale);
		end
		if (ctrl.x60) begin
			inc_q <= (MIN_W'(prod_q) << 6) - (MIN_W'(prod_q) << 2);
		end
	end

	// One adder/subtractor serves both the accumulate and every hour rollover.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= '0;
		end else if (ctrl.add) begin
			min_q <= min_q + inc_q;
		end else if (ctrl.sub) begin
			min_q <= min_q - HOUR_FIX;
		end
	end

	assign hour_over = (min_q >= HOUR_FIX);
	assign minute    = min_q[23:0];

endmodule

// ===== src/sccc_calendar.sv =====
// Hour, day, month and year counters with Gregorian leap years.
// Depends on sccc_pkg.
module sccc_calendar #(
	parameter int YEAR_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 hour_step,
	output logic [YEAR_BITS-1:0] year,
	output logic [3:0]           month,
	output logic [4:0]           day,
	output logic [4:0]           hour,
	output logic                 day_roll
);
	import sccc_pkg::*;

	logic [YEAR_BITS-1:0] year_q;
	logic [3:0]           month_q;
	logic [4:0]           day_q;
	logic [4:0]           hour_q;
	// Year modulo 100 and century modulo 4 replace divisions in the leap test.
	logic [6:0]           ymod100_q;
	logic [1:0]           centmod4_q;
	logic                 leap;
	logic                 month_end;
	logic                 year_end;
	logic                 year_sat;

	assign leap = ((ymod100_q[1:0] == 2'd0) && (ymod100_q != 7'd0)) ||
	              ((ymod100_q == 7'd0) && (centmod4_q == 2'd0));
	assign day_roll  = hour_step && (hour_q == HOURS_PER_DAY - 5'd1);
	assign month_end = (day_q >= month_days(month_q, leap));
	assign year_end  = (month_q == MONTHS_PER_YEAR);
	assign year_sat  = (year_q == {YEAR_BITS{1'b1}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_q     <= YEAR_BITS'(YEAR_RESET);
			month_q    <= 4'd1;
			day_q      <= 5'd1;
			hour_q     <= HOUR_RESET;
			ymod100_q  <= YMOD100_RESET;
			centmod4_q <= CENTMOD4_RESET;
		end else if (hour_step) begin
			if (!day_roll) begin
				hour_q <= hour_q + 5'd1;
			end else begin
				hour_q <= 5'd0;
				if (!month_end) begin
					day_q <= day_q + 5'd1;
				end else begin
					day_q <= 5'd1;
					if (!year_end) begin
						month_q <= month_q + 4'd1;
					end else begin
						month_q <= 4'd1;
						// The year holds at its maximum; the leap counters hold with it.
						if (!year_sat) begin
							year_q <= year_q + YEAR_BITS'(1);
							if (ymod100_q == 7'd99) begin
								ymod100_q  <= 7'd0;
								centmod4_q <= centmod4_q + 2'd1;
							end else begin
								ymod100_q <= ymod100_q + 7'd1;
							end
						end
					end
				end
			end
		end
	end

	assign year  = year_q;
	assign month = month_q;
	assign day   = day_q;
	assign hour  = hour_q;

endmodule

// ===== src/scaled_calendar_clock.sv =====
// Top level of the scaled calendar clock: sequencer, scale register and result word.
// Depends on sccc_pkg, sccc_minute_unit and sccc_calendar.
//
// Each input word is a real-time tick in 1/1024 s. The tick is scaled by the Q7.8
// scale register (written through cfg_we/cfg_wdata, clamped to 100x, 1x after
// reset) and by 60 to give game minutes in 2^-18 minute, which are added to the minute
// store. Whole hours are then taken off one per cycle by a single shared subtractor,
// and each one steps the calendar (hours, days, months, years with Gregorian leap
// years; the year holds at 2^YEAR_BITS-1). The block takes one word at a time: after
// in_valid/in_ready it runs the times-60 step, the add and the hour rollovers (0 to 100
// at 100x) before the result word is offered, and is held longer only while an earlier
// result word still waits on out_ready. A scale of 0 pauses the clock: the tick then
// skips these steps and the result repeats the stored date and time, with no phase
// change. Every result word carries the date, time, day phase, a phase-change flag and
// the day rollovers caused by the tick (saturating at 7). The phase starts as night, so
// the first running tick reports a change unless it ends in a night hour. The scale
// register is to be written only while idle; the block itself does not enforce this.
module scaled_calendar_clock #(
	parameter int YEAR_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [14:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [9:0]  delta_ticks,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] year_now,
	output logic [3:0]  month_now,
	output logic [4:0]  day_now,
	output logic [4:0]  hour_now,
	output logic [23:0] minute_fixed,
	output logic [2:0]  day_phase,
	output logic        phase_changed,
	output logic [2:0]  days_advanced
);
	import sccc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_X60,
		ST_ADD,
		ST_ROLL,
		ST_FIN
	} state_t;

	state_t               state_q;
	logic [14:0]          scale_q;
	day_phase_t           phase_q;
	logic [2:0]           days_q;
	logic                 paused_q;

	logic                 out_valid_q;
	logic [15:0]          out_year_q;
	logic [3:0]           out_month_q;
	logic [4:0]           out_day_q;
	logic [4:0]           out_hour_q;
	logic [23:0]          out_minute_q;
	day_phase_t           out_phase_q;
	logic                 out_changed_q;
	logic [2:0]           out_days_q;

	minute_ctrl_t         mctrl;
	logic [23:0]          minute;
	logic                 hour_over;
	logic                 hour_step;
	logic [YEAR_BITS-1:0] year;
	logic [3:0]           month;
	logic [4:0]           day;
	logic [4:0]           hour;
	logic                 day_roll;
	logic                 accept;
	logic                 out_free;
	logic                 out_load;
	day_phase_t           phase_next;

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign out_free   = !out_valid_q || out_ready;
	assign out_load   = (state_q == ST_FIN) && out_free;
	assign phase_next = phase_of(hour);

	// The multiply is skipped for a paused clock; nothing else moves then either.
	assign mctrl = '{
		load: accept && (scale_q != 15'd0),
		x60:  (state_q == ST_X60),
		add:  (state_q == ST_ADD),
		sub:  (state_q == ST_ROLL) && hour_over
	};
	assign hour_step = mctrl.sub;

	sccc_minute_unit u_minute (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (mctrl),
		.delta_ticks (delta_ticks),
		.scale       (scale_q),
		.minute      (minute),
		.hour_over   (hour_over)
	);

	sccc_calendar #(
		.YEAR_BITS (YEAR_BITS)
	) u_calendar (
		.clk       (clk),
		.arst_n    (arst_n),
		.hour_step (hour_step),
		.year      (year),
		.month     (month),
		.day       (day),
		.hour      (hour),
		.day_roll  (day_roll)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			scale_q       <= SCALE_RESET;
			phase_q       <= PH_NIGHT;
			days_q        <= 3'd0;
			paused_q      <= 1'b0;
			out_valid_q   <= 1'b0;
			out_year_q    <= 16'd0;
			out_month_q   <= 4'd0;
			out_day_q     <= 5'd0;
			out_hour_q    <= 5'd0;
			out_minute_q  <= 24'd0;
			out_phase_q   <= PH_NIGHT;
			out_changed_q <= 1'b0;
			out_days_q    <= 3'd0;
		end else begin
			if (cfg_we) begin
				scale_q <= (cfg_wdata > SCALE_MAX) ? SCALE_MAX : cfg_wdata;
			end
			// A new word may replace one that leaves in the same cycle.
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						days_q   <= 3'd0;
						paused_q <= (scale_q == 15'd0);
						state_q  <= (scale_q == 15'd0) ? ST_FIN : ST_X60;
					end
				end
				ST_X60: state_q <= ST_ADD;
				ST_ADD: state_q <= ST_ROLL;
				ST_ROLL: begin
					// One hour leaves the minute store per cycle until less than an hour is left.
					if (hour_over) begin
						if (day_roll && (days_q != 3'd7)) begin
							days_q <= days_q + 3'd1;
						end
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_load) begin
						out_year_q   <= 16'(year);
						out_month_q  <= month;
						out_day_q    <= day;
						out_hour_q   <= hour;
						out_minute_q <= minute;
						out_days_q   <= days_q;
						if (paused_q) begin
							out_phase_q   <= phase_q;
							out_changed_q <= 1'b0;
						end else begin
							phase_q       <= phase_next;
							out_phase_q   <= phase_next;
							out_changed_q <= (phase_next != phase_q);
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign year_now      = out_year_q;
	assign month_now     = out_month_q;
	assign day_now       = out_day_q;
	assign hour_now      = out_hour_q;
	assign minute_fixed  = out_minute_q;
	assign day_phase     = out_phase_q;
	assign phase_changed = out_changed_q;
	assign days_advanced = out_days_q;

	// A taken word keeps the block busy for at least the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("input taken while previous word still in progress");

	// Between words the minute store always holds less than one hour.
	a_minute_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !hour_over)
		else $error("minute store not normalized while idle");

	// The offered phase always matches the phase kept for the next comparison.
	a_phase_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_phase_q == phase_q))
		else $error("result phase differs from stored phase");

	// The hour never leaves 0..23.
	a_hour_range: assert property (@(posedge clk) disable iff (!arst_n)
		hour < HOURS_PER_DAY)
		else $error("hour counter out of range");

endmodule
